// ===== hw/rtl/assert_macros.svh =====
// assertion helpers included by dpg_back.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion with explicit clock and active-low reset
`define DPG_ASSERT_CR(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the house clock and reset names
`define DPG_ASSERT(lbl, prop, msg) \
    `DPG_ASSERT_CR(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== hw/rtl/dpg_pkg.sv =====
package dpg_pkg;

    // sizing
    localparam int MAX_LEVELS         = 64;
    localparam int TOTAL_STAGE_PARTS  = 8;
    localparam int FIRST_SPLIT_START  = 5;
    localparam int SECOND_SPLIT_START = 8;

    // fixed field widths
    localparam int CNT_W   = 7;
    localparam int SPL_W   = 4;
    localparam int LVL_OUT = 6;
    localparam int EFF_MAX = (MAX_LEVELS < 127) ? MAX_LEVELS : 127;
    localparam int IDX_W   = (EFF_MAX > 2) ? $clog2(EFF_MAX) : 1;

    // queue between classifier and state engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic [15:0]      RST_RATE_TARGET    = 16'd3328;
    localparam logic [15:0]      RST_LATENCY_TARGET = 16'd1920;
    localparam logic [7:0]       RST_RATE_MARGIN    = 8'd20;
    localparam logic [15:0]      RST_LATENCY_MARGIN = 16'd80;
    localparam logic [3:0]       RST_UP_NEED        = 4'd2;
    localparam logic [3:0]       RST_DOWN_NEED      = 4'd2;
    localparam logic [CNT_W-1:0] RST_LEVEL_COUNT    = 7'd8;

    // register indexes
    typedef enum logic [2:0] {
        CFG_RATE_TARGET    = 3'd0,
        CFG_LATENCY_TARGET = 3'd1,
        CFG_RATE_MARGIN    = 3'd2,
        CFG_LATENCY_MARGIN = 3'd3,
        CFG_UP_NEED        = 3'd4,
        CFG_DOWN_NEED      = 3'd5,
        CFG_LITTLE_COUNT   = 3'd6,
        CFG_BIG_COUNT      = 3'd7
    } t_cfg_idx;

    // reported action codes
    typedef enum logic [2:0] {
        ACT_WAIT   = 3'd0,
        ACT_UP     = 3'd1,
        ACT_DOWN   = 3'd2,
        ACT_TRIM   = 3'd3,
        ACT_SPLIT  = 3'd4,
        ACT_STABLE = 3'd5,
        ACT_HALT   = 3'd6
    } t_action;

    typedef struct packed {
        logic [15:0]      rate_target;
        logic [15:0]      latency_target;
        logic [7:0]       rate_margin;
        logic [15:0]      latency_margin;
        logic [3:0]       up_need;
        logic [3:0]       down_need;
        logic [CNT_W-1:0] little_count;
        logic [CNT_W-1:0] big_count;
    } t_cfg;

    // level-count write event toward the state engine
    typedef struct packed {
        logic             little;
        logic             big;
        logic [CNT_W-1:0] count;
    } t_lvl_set;

    // measurement class
    typedef struct packed {
        logic need_up;
        logic comfy;
    } t_cls;

    // level count clamped to 1..MAX_LEVELS
    function automatic logic [CNT_W-1:0] f_eff(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (int'(c) > MAX_LEVELS) begin
            r = CNT_W'(MAX_LEVELS);
        end
        return r;
    endfunction

    // middle level of a cluster
    function automatic logic [IDX_W-1:0] f_mid(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] e;
        e = f_eff(c);
        return IDX_W'(e >> 1);
    endfunction

endpackage

// ===== hw/rtl/dpg_front.sv =====
module dpg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  logic [15:0]   i_rate,
    input  logic [15:0]   i_lat,
    input  dpg_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output dpg_pkg::t_cls o_cls
);

    logic        r_vld;
    logic [15:0] r_rate;
    logic [15:0] r_lat;

    logic [24:0] rate_lhs;
    logic [24:0] rate_rhs;
    logic [16:0] lat_sum;

    // input stage takes a transaction whenever the stage is empty or draining
    assign o_rdy  = !r_vld || !i_q_full;
    assign o_push = r_vld && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_vld && o_rdy) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && o_rdy) begin
            r_rate <= i_rate;
            r_lat  <= i_lat;
        end
    end

    // comfort test: rate*256 >= target*(256+margin) and lat+margin <= target
    assign rate_lhs = {1'b0, r_rate, 8'd0};
    assign rate_rhs = 25'(i_cfg.rate_target * {1'b0, i_cfg.rate_margin + 9'd256});
    assign lat_sum  = {1'b0, r_lat} + {1'b0, i_cfg.latency_margin};

    always_comb begin
        o_cls.need_up = (r_rate < i_cfg.rate_target) || (r_lat > i_cfg.latency_target);
        o_cls.comfy   = (rate_lhs >= rate_rhs) && (lat_sum <= {1'b0, i_cfg.latency_target});
    end

endmodule

// ===== hw/rtl/dpg_queue.sv =====
module dpg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dpg_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_vld,
    output dpg_pkg::t_cls o_data
);

    dpg_pkg::t_cls                     r_mem [dpg_pkg::QUEUE_DEPTH];
    logic [dpg_pkg::QPTR_W-1:0]        r_wptr;
    logic [dpg_pkg::QPTR_W-1:0]        r_rptr;
    logic [dpg_pkg::QCNT_W-1:0]        r_cnt;

    localparam logic [dpg_pkg::QPTR_W-1:0] LAST_PTR = dpg_pkg::QPTR_W'(dpg_pkg::QUEUE_DEPTH - 1);

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == dpg_pkg::QCNT_W'(dpg_pkg::QUEUE_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/dpg_back.sv =====
`include "assert_macros.svh"

module dpg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpg_pkg::t_cfg     i_cfg,
    input  dpg_pkg::t_lvl_set i_set,
    input  logic              i_q_vld,
    input  dpg_pkg::t_cls     i_q_data,
    output logic              o_pop,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [5:0]        o_little,
    output logic [5:0]        o_big,
    output logic [3:0]        o_first,
    output logic [3:0]        o_second,
    output dpg_pkg::t_action  o_action
);

    localparam logic [4:0] TOTAL5 = 5'(dpg_pkg::TOTAL_STAGE_PARTS);

    // governor state
    logic [dpg_pkg::IDX_W-1:0] r_little, n_little;
    logic [dpg_pkg::IDX_W-1:0] r_big, n_big;
    logic [3:0]                r_split_one, n_split_one;
    logic [3:0]                r_split_two, n_split_two;
    logic [3:0]                r_up, n_up;
    logic [3:0]                r_down, n_down;
    logic                      r_halted, n_halted;

    // output register
    logic                      r_out_vld, n_out_vld;
    logic [5:0]                r_o_little, n_o_little;
    logic [5:0]                r_o_big, n_o_big;
    logic [3:0]                r_o_first, n_o_first;
    logic [3:0]                r_o_second, n_o_second;
    dpg_pkg::t_action          r_o_action, n_o_action;

    logic [dpg_pkg::CNT_W-1:0] nl;
    logic [dpg_pkg::CNT_W-1:0] nb;
    logic [dpg_pkg::CNT_W-1:0] little_inc;
    logic [dpg_pkg::CNT_W-1:0] big_inc;
    logic [4:0]                up_sum;
    logic [4:0]                down_sum;
    logic [4:0]                two_next;
    logic                      dir_up;
    logic                      dir_down;
    dpg_pkg::t_action          act;

    assign nl         = dpg_pkg::f_eff(i_cfg.little_count);
    assign nb         = dpg_pkg::f_eff(i_cfg.big_count);
    assign little_inc = dpg_pkg::CNT_W'(r_little) + 1'b1;
    assign big_inc    = dpg_pkg::CNT_W'(r_big) + 1'b1;
    assign up_sum     = {1'b0, r_up} + 5'd1;
    assign down_sum   = {1'b0, r_down} + 5'd1;

    // take the next class when the output register is free or being drained
    assign o_pop = i_q_vld && (!r_out_vld || i_rdy);

    // state update for one measurement
    always_comb begin
        n_little    = r_little;
        n_big       = r_big;
        n_split_one = r_split_one;
        n_split_two = r_split_two;
        n_up        = r_up;
        n_down      = r_down;
        n_halted    = r_halted;
        n_out_vld   = r_out_vld && !i_rdy;
        n_o_little  = r_o_little;
        n_o_big     = r_o_big;
        n_o_first   = r_o_first;
        n_o_second  = r_o_second;
        n_o_action  = r_o_action;
        dir_up      = 1'b0;
        dir_down    = 1'b0;
        two_next    = {1'b0, r_split_two} + 5'd1;
        act         = dpg_pkg::ACT_WAIT;

        if (o_pop) begin
            if (r_halted) begin
                act = dpg_pkg::ACT_HALT;
            end else begin
                // confirmation counters
                if (i_q_data.need_up) begin
                    n_down = '0;
                    if (up_sum >= {1'b0, i_cfg.up_need}) begin
                        n_up   = '0;
                        dir_up = 1'b1;
                    end else begin
                        n_up = up_sum[3:0];
                    end
                end else if (i_q_data.comfy) begin
                    n_up = '0;
                    if (down_sum >= {1'b0, i_cfg.down_need}) begin
                        n_down   = '0;
                        dir_down = 1'b1;
                    end else begin
                        n_down = down_sum[3:0];
                    end
                end else begin
                    n_up   = '0;
                    n_down = '0;
                end

                // level decision
                if (dir_up) begin
                    if (little_inc < nl) begin
                        n_little = r_little + 1'b1;
                    end else if (big_inc < nb) begin
                        n_big = r_big + 1'b1;
                    end
                    act = dpg_pkg::ACT_UP;
                end else if (dir_down) begin
                    if (r_big != '0) begin
                        n_big = r_big - 1'b1;
                    end else if (r_little != '0) begin
                        n_little = r_little - 1'b1;
                    end
                    act = dpg_pkg::ACT_DOWN;
                end else if (!i_q_data.need_up) begin
                    act = dpg_pkg::ACT_STABLE;
                    if (i_q_data.comfy) begin
                        if (r_big != '0) begin
                            n_big = r_big - 1'b1;
                            act   = dpg_pkg::ACT_TRIM;
                        end else if (r_little != '0) begin
                            n_little = r_little - 1'b1;
                            act      = dpg_pkg::ACT_TRIM;
                        end
                    end
                end else if ((little_inc == nl) && (big_inc == nb)) begin
                    // both clusters at top and still failing: repartition, or halt when no split can move
                    if ({1'b0, r_split_two} < TOTAL5) begin
                        if (two_next <= {1'b0, r_split_one}) begin
                            two_next = {1'b0, r_split_one} + 5'd1;
                        end
                        if (two_next > TOTAL5) begin
                            two_next = TOTAL5;
                        end
                        n_split_two = two_next[3:0];
                        n_little    = dpg_pkg::f_mid(nl);
                        n_big       = dpg_pkg::f_mid(nb);
                        act         = dpg_pkg::ACT_SPLIT;
                    end else if (({1'b0, r_split_one} + 5'd1) < {1'b0, r_split_two}) begin
                        n_split_one = r_split_one + 4'd1;
                        n_little    = dpg_pkg::f_mid(nl);
                        n_big       = dpg_pkg::f_mid(nb);
                        act         = dpg_pkg::ACT_SPLIT;
                    end else begin
                        n_halted = 1'b1;
                        act      = dpg_pkg::ACT_HALT;
                    end
                end
            end

            n_out_vld  = 1'b1;
            n_o_little = 6'(n_little);
            n_o_big    = 6'(n_big);
            n_o_first  = n_split_one;
            n_o_second = n_split_two;
            n_o_action = act;
        end

        // level-count writes recenter their cluster
        if (i_set.little) begin
            n_little = dpg_pkg::f_mid(i_set.count);
        end
        if (i_set.big) begin
            n_big = dpg_pkg::f_mid(i_set.count);
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_little    <= dpg_pkg::f_mid(dpg_pkg::RST_LEVEL_COUNT);
            r_big       <= dpg_pkg::f_mid(dpg_pkg::RST_LEVEL_COUNT);
            r_split_one <= 4'(dpg_pkg::FIRST_SPLIT_START);
            r_split_two <= 4'(dpg_pkg::SECOND_SPLIT_START);
            r_up        <= '0;
            r_down      <= '0;
            r_halted    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_little    <= n_little;
            r_big       <= n_big;
            r_split_one <= n_split_one;
            r_split_two <= n_split_two;
            r_up        <= n_up;
            r_down      <= n_down;
            r_halted    <= n_halted;
            r_out_vld   <= n_out_vld;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_o_little <= n_o_little;
        r_o_big    <= n_o_big;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
        r_o_action <= n_o_action;
    end

    assign o_vld    = r_out_vld;
    assign o_little = r_o_little;
    assign o_big    = r_o_big;
    assign o_first  = r_o_first;
    assign o_second = r_o_second;
    assign o_action = r_o_action;

    // checks
    `DPG_ASSERT(a_halt_sticks, r_halted |=> r_halted, "halt flag cleared without reset")
    `DPG_ASSERT(a_split_order, r_split_one < r_split_two, "split points out of order")
    `DPG_ASSERT(a_little_range, dpg_pkg::CNT_W'(r_little) < nl, "little level beyond count")
    `DPG_ASSERT(a_big_range, dpg_pkg::CNT_W'(r_big) < nb, "big level beyond count")

endmodule

// ===== hw/rtl/dvfs_partition_governor_unit.sv =====
// an accepted measurement passes the input register, class queue and output register
// throughput: one measurement per cycle when not stalled; input register, 2-entry
// class queue and output register let the input and output sides stall independently
// the state engine updates its state registers once per popped measurement
// reset: synchronous active-low i_rst_n restores config, levels, splits, counters
module dvfs_partition_governor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] frame_rate, [31:16] frame_latency
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [5:0] little_level, [11:6] big_level,
                                        // [15:12] first_split, [19:16] second_split,
                                        // [23:20] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] action
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    dpg_pkg::t_cfg     r_cfg;
    dpg_pkg::t_lvl_set lvl_set;
    dpg_pkg::t_cls     push_cls;
    dpg_pkg::t_cls     q_cls;
    dpg_pkg::t_action  action;
    logic              push;
    logic              q_full;
    logic              q_vld;
    logic              pop;
    logic [5:0]        little_level;
    logic [5:0]        big_level;
    logic [3:0]        first_split;
    logic [3:0]        second_split;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_target    <= dpg_pkg::RST_RATE_TARGET;
            r_cfg.latency_target <= dpg_pkg::RST_LATENCY_TARGET;
            r_cfg.rate_margin    <= dpg_pkg::RST_RATE_MARGIN;
            r_cfg.latency_margin <= dpg_pkg::RST_LATENCY_MARGIN;
            r_cfg.up_need        <= dpg_pkg::RST_UP_NEED;
            r_cfg.down_need      <= dpg_pkg::RST_DOWN_NEED;
            r_cfg.little_count   <= dpg_pkg::RST_LEVEL_COUNT;
            r_cfg.big_count      <= dpg_pkg::RST_LEVEL_COUNT;
        end else if (i_cfg_we) begin
            unique case (dpg_pkg::t_cfg_idx'(i_cfg_idx))
                dpg_pkg::CFG_RATE_TARGET:    r_cfg.rate_target    <= i_cfg_wdata;
                dpg_pkg::CFG_LATENCY_TARGET: r_cfg.latency_target <= i_cfg_wdata;
                dpg_pkg::CFG_RATE_MARGIN:    r_cfg.rate_margin    <= i_cfg_wdata[7:0];
                dpg_pkg::CFG_LATENCY_MARGIN: r_cfg.latency_margin <= i_cfg_wdata;
                dpg_pkg::CFG_UP_NEED:        r_cfg.up_need        <= i_cfg_wdata[3:0];
                dpg_pkg::CFG_DOWN_NEED:      r_cfg.down_need      <= i_cfg_wdata[3:0];
                dpg_pkg::CFG_LITTLE_COUNT:   r_cfg.little_count   <= i_cfg_wdata[6:0];
                dpg_pkg::CFG_BIG_COUNT:      r_cfg.big_count      <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // level-count writes also recenter the cluster
    always_comb begin
        lvl_set.little = i_cfg_we &&
                         (dpg_pkg::t_cfg_idx'(i_cfg_idx) == dpg_pkg::CFG_LITTLE_COUNT);
        lvl_set.big    = i_cfg_we &&
                         (dpg_pkg::t_cfg_idx'(i_cfg_idx) == dpg_pkg::CFG_BIG_COUNT);
        lvl_set.count  = i_cfg_wdata[6:0];
    end

    // classifier
    dpg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (s_axis_tvalid),
        .o_rdy    (s_axis_tready),
        .i_rate   (s_axis_tdata[15:0]),
        .i_lat    (s_axis_tdata[31:16]),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cls    (push_cls)
    );

    // class queue
    dpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cls),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_data  (q_cls)
    );

    // state engine and output register
    dpg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_set    (lvl_set),
        .i_q_vld  (q_vld),
        .i_q_data (q_cls),
        .o_pop    (pop),
        .o_vld    (m_axis_tvalid),
        .i_rdy    (m_axis_tready),
        .o_little (little_level),
        .o_big    (big_level),
        .o_first  (first_split),
        .o_second (second_split),
        .o_action (action)
    );

    assign m_axis_tdata = {4'd0, second_split, first_split, big_level, little_level};
    assign m_axis_tuser = action;

endmodule

// ===== tb/dvfs_partition_governor_unit_test.sv =====
module dvfs_partition_governor_unit_test;

    import dpg_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // governor settings as last written
    typedef struct {
        logic [15:0] rate_target;
        logic [15:0] latency_target;
        logic [7:0]  rate_margin;
        logic [15:0] latency_margin;
        logic [3:0]  up_need;
        logic [3:0]  down_need;
        logic [6:0]  little_count;
        logic [6:0]  big_count;
    } gov_cfg_t;

    // levels, splits and hit counters
    typedef struct {
        int unsigned little_idx;
        int unsigned big_idx;
        int unsigned split_one;
        int unsigned split_two;
        int unsigned up_streak;
        int unsigned down_streak;
        bit          halted;
    } gov_status_t;

    typedef struct {
        logic [5:0] little;
        logic [5:0] big;
        logic [3:0] first_split;
        logic [3:0] second_split;
        t_action    act;
    } gov_decision_t;

    // governor model and the decisions still owed by the block
    class governor_model;
        gov_cfg_t      cfg;
        gov_status_t   st;
        gov_decision_t decision_q[$];
        int            errors;

        function new();
            cfg.rate_target    = RST_RATE_TARGET;
            cfg.latency_target = RST_LATENCY_TARGET;
            cfg.rate_margin    = RST_RATE_MARGIN;
            cfg.latency_margin = RST_LATENCY_MARGIN;
            cfg.up_need        = RST_UP_NEED;
            cfg.down_need      = RST_DOWN_NEED;
            cfg.little_count   = RST_LEVEL_COUNT;
            cfg.big_count      = RST_LEVEL_COUNT;
            st.little_idx      = eff_levels(cfg.little_count) / 2;
            st.big_idx         = eff_levels(cfg.big_count) / 2;
            st.split_one       = FIRST_SPLIT_START;
            st.split_two       = SECOND_SPLIT_START;
            st.up_streak       = 0;
            st.down_streak     = 0;
            st.halted          = 1'b0;
            errors             = 0;
        endfunction

        // level count clamped to 1..MAX_LEVELS
        function int unsigned eff_levels(logic [6:0] c);
            if (c == 7'd0) begin
                return 1;
            end
            if (int'(c) > MAX_LEVELS) begin
                return MAX_LEVELS;
            end
            return c;
        endfunction

        function void apply_reg(t_cfg_idx idx, logic [15:0] v);
            case (idx)
                CFG_RATE_TARGET:    cfg.rate_target = v;
                CFG_LATENCY_TARGET: cfg.latency_target = v;
                CFG_RATE_MARGIN:    cfg.rate_margin = v[7:0];
                CFG_LATENCY_MARGIN: cfg.latency_margin = v;
                CFG_UP_NEED:        cfg.up_need = v[3:0];
                CFG_DOWN_NEED:      cfg.down_need = v[3:0];
                CFG_LITTLE_COUNT: begin
                    cfg.little_count = v[6:0];
                    st.little_idx = eff_levels(v[6:0]) / 2;
                end
                CFG_BIG_COUNT: begin
                    cfg.big_count = v[6:0];
                    st.big_idx = eff_levels(v[6:0]) / 2;
                end
                default: ;
            endcase
        endfunction

        // push the second split first, then the first one
        function bit shift_split();
            if (st.split_two < TOTAL_STAGE_PARTS) begin
                st.split_two++;
                if (st.split_two <= st.split_one) begin
                    st.split_two = st.split_one + 1;
                end
                if (st.split_two > TOTAL_STAGE_PARTS) begin
                    st.split_two = TOTAL_STAGE_PARTS;
                end
                return 1'b1;
            end
            if (st.split_one + 1 < st.split_two) begin
                st.split_one++;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // one measurement: update state and return the decision
        function gov_decision_t decide(logic [15:0] rate, logic [15:0] lat);
            int unsigned       nl;
            int unsigned       nb;
            int unsigned       lat_sum;
            longint unsigned   rate_scaled;
            longint unsigned   rate_needed;
            bit                need_up;
            bit                comfy;
            bit                go_up;
            bit                go_down;
            t_action           act;
            gov_decision_t     d;
            nl = eff_levels(cfg.little_count);
            nb = eff_levels(cfg.big_count);
            go_up = 1'b0;
            go_down = 1'b0;
            act = ACT_WAIT;
            if (st.halted) begin
                act = ACT_HALT;
            end else begin
                need_up = (rate < cfg.rate_target) || (lat > cfg.latency_target);
                rate_scaled = rate;
                rate_scaled = rate_scaled * 256;
                rate_needed = cfg.rate_target;
                rate_needed = rate_needed * (256 + cfg.rate_margin);
                lat_sum = lat;
                lat_sum = lat_sum + cfg.latency_margin;
                comfy = (rate_scaled >= rate_needed) && (lat_sum <= cfg.latency_target);

                // confirmation counters
                if (need_up) begin
                    st.up_streak++;
                    st.down_streak = 0;
                    if (st.up_streak >= cfg.up_need) begin
                        st.up_streak = 0;
                        go_up = 1'b1;
                    end
                end else if (comfy) begin
                    st.down_streak++;
                    st.up_streak = 0;
                    if (st.down_streak >= cfg.down_need) begin
                        st.down_streak = 0;
                        go_down = 1'b1;
                    end
                end else begin
                    st.up_streak = 0;
                    st.down_streak = 0;
                end

                // level moves, trim and partition fallback
                if (go_up) begin
                    if (st.little_idx + 1 < nl) begin
                        st.little_idx++;
                    end else if (st.big_idx + 1 < nb) begin
                        st.big_idx++;
                    end
                    act = ACT_UP;
                end else if (go_down) begin
                    if (st.big_idx > 0) begin
                        st.big_idx--;
                    end else if (st.little_idx > 0) begin
                        st.little_idx--;
                    end
                    act = ACT_DOWN;
                end else if (!need_up) begin
                    act = ACT_STABLE;
                    if (comfy) begin
                        if (st.big_idx > 0) begin
                            st.big_idx--;
                            act = ACT_TRIM;
                        end else if (st.little_idx > 0) begin
                            st.little_idx--;
                            act = ACT_TRIM;
                        end
                    end
                end else if (st.little_idx + 1 == nl && st.big_idx + 1 == nb) begin
                    if (shift_split()) begin
                        st.little_idx = nl / 2;
                        st.big_idx = nb / 2;
                        act = ACT_SPLIT;
                    end else begin
                        st.halted = 1'b1;
                        act = ACT_HALT;
                    end
                end
            end
            d.little       = 6'(st.little_idx);
            d.big          = 6'(st.big_idx);
            d.first_split  = 4'(st.split_one);
            d.second_split = 4'(st.split_two);
            d.act          = act;
            return d;
        endfunction

        // action a measurement would cause, state left untouched
        function t_action peek_action(logic [15:0] rate, logic [15:0] lat);
            gov_status_t   saved;
            gov_decision_t d;
            saved = st;
            d = decide(rate, lat);
            st = saved;
            return d.act;
        endfunction

        function void note_measure(logic [15:0] rate, logic [15:0] lat);
            decision_q.push_back(decide(rate, lat));
        endfunction

        function int pending();
            return decision_q.size();
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_decision(logic [23:0] data, logic [2:0] user);
            gov_decision_t want;
            if (decision_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none actual data %h action %0d",
                         $time, data, user);
                return;
            end
            want = decision_q.pop_front();
            compare("little_level", want.little, data[5:0]);
            compare("big_level", want.big, data[11:6]);
            compare("first_split", want.first_split, data[15:12]);
            compare("second_split", want.second_split, data[19:16]);
            compare("tdata padding", 8'd0, data[23:20]);
            compare("action", want.act, user);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    governor_model governor;
    bit            tx_burst = 1'b0;
    bit            rx_burst = 1'b0;
    int            sent = 0;
    int            idle_cycles = 0;

    dvfs_partition_governor_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one measurement transaction, preceded by a random gap unless in burst mode
    task automatic send_measure(input logic [15:0] rate, input logic [15:0] lat);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {lat, rate};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        governor.note_measure(rate, lat);
        sent++;
    endtask

    // result side with random stalls unless in burst mode
    task automatic take_results();
        int stall;
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            governor.check_decision(m_axis_tdata, m_axis_tuser);
        end
    endtask

    // stop sending and wait for every owed decision
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (governor.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        governor.apply_reg(idx, value);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] reg_value(t_cfg_idx idx);
        int pick;
        pick = $urandom_range(0, 7);
        case (idx)
            CFG_RATE_TARGET: begin
                if (pick == 0) return 16'd0;
                if (pick == 1) return 16'hFFFF;
                if (pick == 2) return 16'($urandom);
                return 16'($urandom_range(1000, 8000));
            end
            CFG_LATENCY_TARGET: begin
                if (pick == 0) return 16'd0;
                if (pick == 1) return 16'hFFFF;
                if (pick == 2) return 16'($urandom);
                return 16'($urandom_range(500, 4000));
            end
            CFG_RATE_MARGIN: begin
                if (pick == 0) return 16'd0;
                if (pick == 1) return 16'd255;
                return 16'($urandom_range(0, 255));
            end
            CFG_LATENCY_MARGIN: begin
                if (pick == 0) return 16'd0;
                if (pick == 1) return 16'hFFFF;
                if (pick == 2) return 16'($urandom);
                return 16'($urandom_range(0, 300));
            end
            CFG_UP_NEED, CFG_DOWN_NEED: begin
                if (pick == 0) return 16'd0;
                if (pick == 1) return 16'd15;
                if (pick == 2) return 16'($urandom_range(0, 15));
                return 16'($urandom_range(0, 3));
            end
            default: begin
                // level counts: mostly small so the top level is reachable
                if (pick == 0) return 16'd0;
                if (pick == 1) return 16'd1;
                if (pick == 2) return 16'd64;
                if (pick == 3) return 16'd127;
                if (pick == 4) return 16'($urandom_range(65, 127));
                return 16'($urandom_range(1, 8));
            end
        endcase
    endfunction

    task automatic random_config(input bit all_regs);
        for (int i = 0; i < 8; i++) begin
            if (all_regs || $urandom_range(0, 2) != 0) begin
                write_reg(t_cfg_idx'(i), reg_value(t_cfg_idx'(i)));
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] fit16(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return 16'(v);
    endfunction

    // measurement shaped around the current targets
    task automatic pick_measure(output logic [15:0] rate, output logic [15:0] lat);
        int rt;
        int lt;
        int lm;
        int need;
        int kind;
        rt = governor.cfg.rate_target;
        lt = governor.cfg.latency_target;
        lm = governor.cfg.latency_margin;
        need = (rt * (256 + int'(governor.cfg.rate_margin)) + 255) / 256;
        kind = $urandom_range(0, 9);
        rate = 16'($urandom);
        lat = 16'($urandom);
        if (kind <= 3) begin
            // failing measurement
            if (rt > 0 && (lt == 65535 || $urandom_range(0, 1) == 1)) begin
                rate = 16'($urandom_range(0, rt - 1));
            end else if (lt < 65535) begin
                lat = 16'($urandom_range(lt + 1, 65535));
            end
        end else if (kind <= 6) begin
            // comfortable measurement
            if (need <= 65535) begin
                rate = 16'($urandom_range(need, (need + 600 > 65535) ? 65535 : need + 600));
            end
            if (lt >= lm) begin
                lat = 16'($urandom_range(0, lt - lm));
            end
        end else if (kind <= 8) begin
            // right on a threshold
            case ($urandom_range(0, 3))
                0: rate = fit16(rt - 1);
                1: rate = fit16(rt);
                2: rate = fit16(need - 1);
                default: rate = fit16(need);
            endcase
            case ($urandom_range(0, 3))
                0: lat = fit16(lt);
                1: lat = fit16(lt + 1);
                2: lat = fit16(lt - lm);
                default: lat = fit16(lt - lm + 1);
            endcase
        end
    endtask

    initial begin
        logic [15:0] rate;
        logic [15:0] lat;
        bit          first_phase;
        governor = new();
        first_phase = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_results();
        join_none

        // directed: reset settings, field extremes, wait/up/trim/down/stable
        send_measure(16'd0, 16'hFFFF);
        send_measure(16'd0, 16'd0);
        send_measure(16'hFFFF, 16'd0);
        send_measure(16'hFFFF, 16'd0);
        send_measure(16'd3328, 16'd1920);
        send_measure(16'd3328, 16'd1921);
        send_measure(16'd3327, 16'd0);
        send_measure(16'hFFFF, 16'hFFFF);

        // zero confirmation, single-level little cluster, steps at the limits
        drain();
        write_reg(CFG_UP_NEED, 16'd0);
        write_reg(CFG_DOWN_NEED, 16'd0);
        write_reg(CFG_LITTLE_COUNT, 16'd0);
        write_reg(CFG_BIG_COUNT, 16'd2);
        i_cfg_we <= 1'b0;
        send_measure(16'd0, 16'd0);
        send_measure(16'hFFFF, 16'd0);
        send_measure(16'hFFFF, 16'd0);

        // oversized level counts and trims while the down count is pending
        drain();
        write_reg(CFG_UP_NEED, 16'd15);
        write_reg(CFG_DOWN_NEED, 16'd15);
        write_reg(CFG_LITTLE_COUNT, 16'd127);
        write_reg(CFG_BIG_COUNT, 16'd127);
        i_cfg_we <= 1'b0;
        send_measure(16'hFFFF, 16'd0);
        send_measure(16'hFFFF, 16'd0);
        send_measure(16'hFFFF, 16'd0);
        send_measure(16'd0, 16'd0);
        drain();
        write_reg(CFG_RATE_MARGIN, 16'd255);
        write_reg(CFG_LATENCY_MARGIN, 16'hFFFF);
        i_cfg_we <= 1'b0;
        send_measure(16'hFFFF, 16'd0);
        send_measure(16'd5000, 16'd100);

        // random phases, halting kept back for the last one
        while (sent < 1850) begin
            drain();
            random_config(first_phase);
            first_phase = 1'b0;
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(60, 140)) begin
                if ($urandom_range(0, 59) == 0) begin
                    drain();
                end
                pick_measure(rate, lat);
                if (governor.peek_action(rate, lat) == ACT_HALT) begin
                    rate = 16'hFFFF;
                    lat = 16'd0;
                end
                send_measure(rate, lat);
            end
        end

        // single-level clusters: use up the split moves, then halt
        drain();
        write_reg(CFG_UP_NEED, 16'd2);
        write_reg(CFG_LITTLE_COUNT, 16'd1);
        write_reg(CFG_BIG_COUNT, 16'd1);
        i_cfg_we <= 1'b0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        repeat (12) send_measure(16'd0, 16'hFFFF);
        repeat (80) begin
            pick_measure(rate, lat);
            send_measure(rate, lat);
        end

        // writes still land while halted
        drain();
        write_reg(CFG_LITTLE_COUNT, 16'd5);
        write_reg(CFG_RATE_TARGET, 16'd0);
        i_cfg_we <= 1'b0;
        repeat (20) begin
            pick_measure(rate, lat);
            send_measure(rate, lat);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (governor.errors == 0 && governor.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
